/* rtl/hrf_pkg.sv */
// Package: types, constants and helpers for the HTTP response framer.
`timescale 1ns / 1ps
package hrf_pkg;

   localparam int unsigned COUNT_BITS_DEF = 32;
   localparam int unsigned STATUS_MAX     = 99999;
   localparam int unsigned MIN_MSG        = 12;
   localparam int unsigned TE_LEN         = 17;
   localparam int unsigned CL_LEN         = 14;
   localparam int unsigned CK_LEN         = 7;
   localparam int unsigned QUEUE_DEPTH    = 4;

   localparam logic [4:0] PH_SL_PRE   = 5'd0;
   localparam logic [4:0] PH_SL_WS    = 5'd1;
   localparam logic [4:0] PH_SL_DIG   = 5'd2;
   localparam logic [4:0] PH_SL_REST  = 5'd3;
   localparam logic [4:0] PH_HNAME    = 5'd4;
   localparam logic [4:0] PH_TE_WS    = 5'd5;
   localparam logic [4:0] PH_TE_VAL   = 5'd6;
   localparam logic [4:0] PH_CL_WS    = 5'd7;
   localparam logic [4:0] PH_CL_DIG   = 5'd8;
   localparam logic [4:0] PH_HSKIP    = 5'd9;
   localparam logic [4:0] PH_CH_SIZE  = 5'd10;
   localparam logic [4:0] PH_CH_EXT   = 5'd11;
   localparam logic [4:0] PH_CH_DATA  = 5'd12;
   localparam logic [4:0] PH_CH_TRAIL = 5'd13;
   localparam logic [4:0] PH_CH_DONE  = 5'd14;
   localparam logic [4:0] PH_PLAIN    = 5'd15;
   localparam logic [4:0] PH_ERR      = 5'd16;

   localparam logic [1:0] MODE_CHUNKED = 2'd0;
   localparam logic [1:0] MODE_LENGTH  = 2'd1;
   localparam logic [1:0] MODE_CLOSE   = 2'd2;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_msg;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  body_byte;
      logic [17:0] status_code;
      logic [31:0] body_length;
      logic [1:0]  framing_mode;
      logic        parse_error;
      logic        last_result;
   } rsp_type;

   // One decoded byte event from the parser to the emitter.
   typedef struct packed {
      logic        emit_byte;
      logic [7:0]  body_byte;
      logic        emit_sum;
      logic [17:0] status_code;
      logic [31:0] body_length;
      logic [1:0]  framing_mode;
      logic        parse_error;
   } evt_type;

   function automatic logic [7:0] te_char(input logic [4:0] i);
      logic [7:0] c;
      case (i)
         5'd0: c = "t";  5'd1: c = "r";  5'd2: c = "a";  5'd3: c = "n";
         5'd4: c = "s";  5'd5: c = "f";  5'd6: c = "e";  5'd7: c = "r";
         5'd8: c = "-";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "c";
         5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
         5'd16: c = "g";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      logic [7:0] c;
      case (i)
         5'd0: c = "c";  5'd1: c = "o";  5'd2: c = "n";  5'd3: c = "t";
         5'd4: c = "e";  5'd5: c = "n";  5'd6: c = "t";  5'd7: c = "-";
         5'd8: c = "l";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "g";
         5'd12: c = "t"; 5'd13: c = "h";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] ck_char(input logic [4:0] i);
      logic [7:0] c;
      case (i)
         5'd0: c = "c"; 5'd1: c = "h"; 5'd2: c = "u"; 5'd3: c = "n";
         5'd4: c = "k"; 5'd5: c = "e"; 5'd6: c = "d";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

endpackage

/* rtl/http_response_framer.sv */
// Top level of the HTTP/1.1 response framer.
`timescale 1ns / 1ps
// Usage:
// req_ channel: one raw message byte per transfer, end_of_msg on the last one.
// rsp_ channel: decoded body bytes (kind 0), then one summary (kind 1,
// last_result 1) per message with status, body length, framing and error.
// Body bytes already sent for a message whose summary flags an error are to
// be dropped by the receiver.
// Throughput: one byte per cycle while req_stall is low. A byte that yields both a
// body byte and the summary gives two transfers through the single output register.
// Path: a result reaches rsp_ through the parser event register, the
// four-entry queue and the output register, in that order.
// Reset clears the parser to the start of a message and empties the queue.
// A stalled receiver holds rsp_ stable; the queue fills and then req_stall
// rises, so no byte is lost.
module http_response_framer
   import hrf_pkg::*;
#(
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic    p_ready, pe_valid, q_ready, qe_valid, e_ready;
   evt_type pe_data, qe_data;

   assign req_stall = !p_ready;

   hrf_parser #(.COUNT_BITS(COUNT_BITS)) u_parser (
      .clock, .reset, .in_valid(req_valid), .in_data(req_data), .in_ready(p_ready),
      .evt_valid(pe_valid), .evt_data(pe_data), .evt_ready(q_ready));

   hrf_queue u_queue (
      .clock, .reset, .wr_valid(pe_valid), .wr_data(pe_data), .wr_ready(q_ready),
      .rd_valid(qe_valid), .rd_data(qe_data), .rd_ready(e_ready));

   hrf_emitter u_emitter (
      .clock, .reset, .evt_valid(qe_valid), .evt_data(qe_data), .evt_ready(e_ready),
      .out_valid(rsp_valid), .out_data(rsp_data), .out_stall(rsp_stall));

endmodule

/* rtl/hrf_parser.sv */
// Front end: parses one message byte per cycle while its event output is not stalled, and produces decode events.
`timescale 1ns / 1ps
module hrf_parser
   import hrf_pkg::*;
#(
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_data,
   output logic    in_ready,
   output logic    evt_valid,
   output evt_type evt_data,
   input  logic    evt_ready
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam int unsigned LEN_BITS = (COUNT_BITS < 32) ? COUNT_BITS : 32;

   logic [4:0]            phase_ff, phase_in;
   logic                  cr_ff, cr_in;
   logic [16:0]           stv_ff, stv_in;
   logic                  stn_ff, stn_in;
   logic [4:0]            pos_ff, pos_in;
   logic [1:0]            nmf_ff, nmf_in;
   logic                  vmf_ff, vmf_in;
   logic                  es_ff, es_in;
   logic                  ec_ff, ec_in;
   logic                  ls_ff, ls_in;
   logic                  ln_ff, ln_in;
   logic [COUNT_BITS-1:0] lv_ff, lv_in;
   logic [COUNT_BITS-1:0] cr_rem_ff, cr_rem_in;
   logic [COUNT_BITS-1:0] dc_ff, dc_in;
   logic [3:0]            sc_ff, sc_in;
   logic                  ev_ff, ev_in;
   evt_type               ed_ff, ed_in;

   logic       take;
   logic [7:0] b;

   assign in_ready  = !ev_ff || evt_ready;
   assign take      = in_valid && in_ready;
   assign b         = in_data.byte_in;
   assign evt_valid = ev_ff;
   assign evt_data  = ed_ff;

   function automatic logic [COUNT_BITS-1:0] acc10(input logic [COUNT_BITS-1:0] v,
                                                  input logic [7:0] c);
      logic [COUNT_BITS+3:0] w;
      w = {4'd0, v} * (COUNT_BITS+4)'(10) + (COUNT_BITS+4)'(c - "0");
      return (w > {4'd0, CNT_MAX}) ? CNT_MAX : w[COUNT_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] acc16(input logic [COUNT_BITS-1:0] v,
                                                  input logic [3:0] h);
      return (v[COUNT_BITS-1 -: 4] != 4'd0) ? CNT_MAX : {v[COUNT_BITS-5:0], h};
   endfunction

   always_comb begin
      logic [7:0]  lc, hc;
      logic        hex_ok, do_content, emit, te, cl, err;
      logic [3:0]  hv;
      logic [20:0] sv;
      logic [17:0] st;
      logic [4:0]  phase_x, pos_x;
      logic [1:0]  nmf_x;
      logic        vmf_x;
      phase_in = phase_ff; cr_in = cr_ff; stv_in = stv_ff; stn_in = stn_ff;
      pos_in = pos_ff; nmf_in = nmf_ff; vmf_in = vmf_ff; es_in = es_ff;
      ec_in = ec_ff; ls_in = ls_ff; ln_in = ln_ff; lv_in = lv_ff;
      cr_rem_in = cr_rem_ff; dc_in = dc_ff; sc_in = sc_ff;
      ev_in = ev_ff && !evt_ready; ed_in = ed_ff;
      emit = 1'b0; do_content = 1'b0; hc = b; lc = to_lower(b);
      te = 1'b0; cl = 1'b0; err = 1'b0; st = '0; sv = '0;
      phase_x = phase_ff; pos_x = pos_ff; nmf_x = nmf_ff; vmf_x = vmf_ff;
      hex_ok = 1'b0; hv = '0;
      if (b >= "0" && b <= "9") begin hex_ok = 1'b1; hv = 4'(b - "0"); end
      else if (b >= "a" && b <= "f") begin hex_ok = 1'b1; hv = 4'(b - "a" + 8'd10); end
      else if (b >= "A" && b <= "F") begin hex_ok = 1'b1; hv = 4'(b - "A" + 8'd10); end
      if (take) begin
         if (sc_ff < 4'(MIN_MSG)) sc_in = sc_ff + 4'd1;
         if (phase_ff <= PH_HSKIP) begin
            if (b == 8'h00) phase_in = PH_ERR;
            else begin
               if (cr_ff && b == 8'h0A) begin
                  cr_in = 1'b0;
                  // End of line.
                  if (phase_ff == PH_SL_PRE) phase_in = PH_ERR;
                  else if (phase_ff == PH_HNAME && pos_ff == 5'd0) begin
                     cr_rem_in = '0;
                     phase_in  = (es_ff && ec_ff) ? PH_CH_SIZE : PH_PLAIN;
                  end else begin
                     if (phase_ff == PH_TE_WS || phase_ff == PH_TE_VAL)
                        ec_in = vmf_ff && pos_ff == 5'(CK_LEN);
                     if (ln_ff) begin lv_in = '0; ln_in = 1'b0; end
                     phase_in = PH_HNAME; pos_in = '0; nmf_in = 2'b11;
                  end
               end else begin
                  // A CR left pending by the previous byte counts as line content
                  // first; the current byte is then handled on top of that.
                  if (cr_ff) begin
                     unique case (phase_ff)
                        PH_SL_WS, PH_SL_DIG: phase_x = PH_SL_REST;
                        PH_HNAME: begin
                           nmf_x = 2'b00;
                           if (pos_ff < 5'd31) pos_x = pos_ff + 5'd1;
                        end
                        PH_TE_WS, PH_TE_VAL: begin
                           phase_x = PH_TE_VAL; vmf_x = 1'b0;
                           if (pos_ff < 5'd31) pos_x = pos_ff + 5'd1;
                        end
                        PH_CL_WS, PH_CL_DIG: phase_x = PH_HSKIP;
                        default: ;
                     endcase
                  end
                  phase_in = phase_x; pos_in = pos_x; nmf_in = nmf_x; vmf_in = vmf_x;
                  do_content = (b != 8'h0D);
                  cr_in = (b == 8'h0D);
               end
            end
         end else if (phase_ff != PH_ERR) begin
            unique case (phase_ff)
               PH_CH_SIZE, PH_CH_TRAIL: begin
                  if (phase_ff == PH_CH_TRAIL && (b == 8'h0D || b == 8'h0A)) begin
                  end else begin
                     if (hex_ok)
                        cr_rem_in = acc16((phase_ff == PH_CH_TRAIL) ? '0 : cr_rem_ff, hv);
                     else begin
                        if (phase_ff == PH_CH_TRAIL) cr_rem_in = '0;
                        if (b == 8'h0A)
                           phase_in = ((phase_ff == PH_CH_TRAIL) || cr_rem_ff == '0)
                                      ? PH_CH_DONE : PH_CH_DATA;
                        else phase_in = PH_CH_EXT;
                     end
                     if (phase_ff == PH_CH_TRAIL && hex_ok) phase_in = PH_CH_SIZE;
                  end
               end
               PH_CH_EXT:
                  if (b == 8'h0A) phase_in = (cr_rem_ff == '0) ? PH_CH_DONE : PH_CH_DATA;
               PH_CH_DATA: begin
                  cr_rem_in = cr_rem_ff - 1'b1;
                  if (cr_rem_ff == {{(COUNT_BITS-1){1'b0}}, 1'b1}) phase_in = PH_CH_TRAIL;
                  emit = 1'b1;
               end
               PH_PLAIN:
                  emit = !(es_ff && ec_ff) && !(ls_ff && dc_ff >= lv_ff);
               default: ;
            endcase
         end
         if (do_content) begin
            unique case (phase_x)
               PH_SL_PRE: if (hc == " ") phase_in = PH_SL_WS;
               PH_SL_WS, PH_SL_DIG: begin
                  if (phase_x == PH_SL_WS && (hc == " " || hc == 8'h09)) ;
                  else if (phase_x == PH_SL_WS && hc == "-") begin
                     stn_in = 1'b1; phase_in = PH_SL_DIG;
                  end else if (phase_x == PH_SL_WS && hc == "+") phase_in = PH_SL_DIG;
                  else if (is_dec(hc)) begin
                     sv = {4'd0, stv_ff} * 21'd10 + 21'(hc - "0");
                     stv_in = (sv > 21'(STATUS_MAX)) ? 17'(STATUS_MAX) : sv[16:0];
                     phase_in = PH_SL_DIG;
                  end else phase_in = PH_SL_REST;
               end
               PH_HNAME: begin
                  if (hc == ":") begin
                     te = nmf_x[0] && pos_x == 5'(TE_LEN) && !es_ff;
                     cl = nmf_x[1] && pos_x == 5'(CL_LEN) && !ls_ff;
                     pos_in = '0;
                     if (te) begin
                        es_in = 1'b1; ec_in = 1'b0; vmf_in = 1'b1; phase_in = PH_TE_WS;
                     end else if (cl) begin
                        ls_in = 1'b1; lv_in = '0; ln_in = 1'b0; phase_in = PH_CL_WS;
                     end else phase_in = PH_HSKIP;
                  end else begin
                     if (pos_x >= 5'(TE_LEN) || lc != te_char(pos_x)) nmf_in[0] = 1'b0;
                     if (pos_x >= 5'(CL_LEN) || lc != cl_char(pos_x)) nmf_in[1] = 1'b0;
                     if (pos_x < 5'd31) pos_in = pos_x + 5'd1;
                  end
               end
               PH_TE_WS, PH_TE_VAL: begin
                  if (phase_x == PH_TE_WS && (hc == " " || hc == 8'h09)) ;
                  else begin
                     phase_in = PH_TE_VAL;
                     if (pos_x >= 5'(CK_LEN) || lc != ck_char(pos_x)) vmf_in = 1'b0;
                     if (pos_x < 5'd31) pos_in = pos_x + 5'd1;
                  end
               end
               PH_CL_WS, PH_CL_DIG: begin
                  if (phase_x == PH_CL_WS && (hc == " " || hc == 8'h09)) ;
                  else if (phase_x == PH_CL_WS && hc == "-") begin
                     ln_in = 1'b1; phase_in = PH_CL_DIG;
                  end else if (phase_x == PH_CL_WS && hc == "+") phase_in = PH_CL_DIG;
                  else if (is_dec(hc)) begin
                     lv_in = acc10(lv_ff, hc); phase_in = PH_CL_DIG;
                  end else phase_in = PH_HSKIP;
               end
               default: ;
            endcase
         end
         if (emit && dc_ff != CNT_MAX) dc_in = dc_ff + 1'b1;
         ed_in = '0;
         ed_in.emit_byte = emit;
         ed_in.body_byte = b;
         if (in_data.end_of_msg) begin
            err = (phase_in <= PH_HSKIP) || phase_in == PH_ERR ||
                  sc_in < 4'(MIN_MSG);
            ed_in.emit_sum = 1'b1;
            ed_in.parse_error = err;
            if (!err) begin
               st = {1'b0, stv_in};
               ed_in.status_code  = stn_in ? (~st + 18'd1) : st;
               ed_in.body_length  = 32'(dc_in[LEN_BITS-1:0]);
               if (COUNT_BITS > 32 && (dc_in >> LEN_BITS) != '0)
                  ed_in.body_length = '1;
               ed_in.framing_mode = (es_in && ec_in) ? MODE_CHUNKED :
                                    (ls_in ? MODE_LENGTH : MODE_CLOSE);
            end
            phase_in = PH_SL_PRE; cr_in = 1'b0; stv_in = '0; stn_in = 1'b0;
            pos_in = '0; nmf_in = 2'b11; vmf_in = 1'b1; es_in = 1'b0;
            ec_in = 1'b0; ls_in = 1'b0; ln_in = 1'b0; lv_in = '0;
            cr_rem_in = '0; dc_in = '0; sc_in = '0;
         end
         ev_in = emit || in_data.end_of_msg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SL_PRE; cr_ff <= 1'b0; stv_ff <= '0; stn_ff <= 1'b0;
         pos_ff <= '0; nmf_ff <= 2'b11; vmf_ff <= 1'b1; es_ff <= 1'b0;
         ec_ff <= 1'b0; ls_ff <= 1'b0; ln_ff <= 1'b0; lv_ff <= '0;
         cr_rem_ff <= '0; dc_ff <= '0; sc_ff <= '0; ev_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; cr_ff <= cr_in; stv_ff <= stv_in; stn_ff <= stn_in;
         pos_ff <= pos_in; nmf_ff <= nmf_in; vmf_ff <= vmf_in; es_ff <= es_in;
         ec_ff <= ec_in; ls_ff <= ls_in; ln_ff <= ln_in; lv_ff <= lv_in;
         cr_rem_ff <= cr_rem_in; dc_ff <= dc_in; sc_ff <= sc_in; ev_ff <= ev_in;
      end
      ed_ff <= ed_in;
   end

`ifndef SYNTHESIS
   a_evt_hold: assert property (@(posedge clock) disable iff (reset)
      ev_ff && !evt_ready |=> ev_ff && $stable(ed_ff))
      else $error("decode event dropped while stalled");
   a_evt_nonempty: assert property (@(posedge clock) disable iff (reset)
      ev_ff |-> ed_ff.emit_byte || ed_ff.emit_sum)
      else $error("empty decode event");
   a_sum_reset: assert property (@(posedge clock) disable iff (reset)
      take && in_data.end_of_msg |=> phase_ff == PH_SL_PRE && sc_ff == 4'd0)
      else $error("state not cleared after message end");
`endif

endmodule

/* rtl/hrf_queue.sv */
// Short event queue between parser and emitter.
`timescale 1ns / 1ps
module hrf_queue
   import hrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  evt_type wr_data,
   output logic    wr_ready,
   output logic    rd_valid,
   output evt_type rd_data,
   input  logic    rd_ready
);

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);

   evt_type       mem_ff [QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          wr, rd;

   assign wr_ready = cnt_ff != (AW+1)'(QUEUE_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rp_ff];
   assign wr       = wr_valid && wr_ready;
   assign rd       = rd_valid && rd_ready;

   always_comb begin
      wp_in  = wr ? wp_ff + 1'b1 : wp_ff;
      rp_in  = rd ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == (AW+1)'(QUEUE_DEPTH)) |-> wp_ff == rp_ff)
      else $error("queue pointers out of step");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      wr && !rd |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("queue count slip");
`endif

endmodule

/* rtl/hrf_emitter.sv */
// Back end: turns decode events into one or two result transfers.
`timescale 1ns / 1ps
module hrf_emitter
   import hrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    evt_valid,
   input  evt_type evt_data,
   output logic    evt_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_stall
);

   logic    byte_done_ff, byte_done_in;
   logic    ov_ff, ov_in;
   rsp_type od_ff, od_in;
   logic    load, sum_now;

   // Byte part goes first; the summary follows when both are present.
   assign sum_now   = !evt_data.emit_byte || byte_done_ff;
   assign load      = evt_valid && (!ov_ff || !out_stall);
   assign evt_ready = load && (sum_now ? 1'b1 : !evt_data.emit_sum);
   assign out_valid = ov_ff;
   assign out_data  = od_ff;

   always_comb begin
      ov_in = ov_ff && out_stall;
      od_in = od_ff;
      byte_done_in = byte_done_ff;
      if (load) begin
         ov_in = 1'b1;
         od_in = '0;
         if (!sum_now) begin
            od_in.body_byte = evt_data.body_byte;
            byte_done_in = evt_data.emit_sum;
         end else begin
            od_in.kind = 1'b1;
            od_in.status_code = evt_data.status_code;
            od_in.body_length = evt_data.body_length;
            od_in.framing_mode = evt_data.framing_mode;
            od_in.parse_error = evt_data.parse_error;
            od_in.last_result = 1'b1;
            byte_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0; byte_done_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in; byte_done_ff <= byte_done_in;
      end
      od_ff <= od_in;
   end

`ifndef SYNTHESIS
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> od_ff.kind == od_ff.last_result) else $error("kind/last mismatch");
   a_split: assert property (@(posedge clock) disable iff (reset)
      byte_done_ff |-> evt_valid && evt_data.emit_sum) else $error("split lost");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      ov_ff && od_ff.parse_error |-> od_ff.body_length == '0)
      else $error("error summary with length");
`endif

endmodule
